// ----- hdl/acvlc_pkg.sv -----
// package for the ac run/level vlc decoder
// holds widths, result kinds, item classes, state codes and the vlc lookup tables
// no dependencies
package acvlc_pkg;

    localparam int WORD_W      = 16;
    localparam int WIN_W       = 22;
    localparam int BUF_W       = WIN_W - 1 + WORD_W;
    localparam int CNT_W       = 6;
    localparam int K_W         = 3;
    localparam int MAX_RESULTS = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CNT_W-1:0]  WORD_CNT = CNT_W'(WORD_W);
    localparam logic [CNT_W-1:0]  PEND_MAX = CNT_W'(WIN_W - 1);
    localparam logic [K_W-1:0]    K_LAST   = K_W'(MAX_RESULTS);
    localparam logic [QCNT_W-1:0] Q_FULL   = QCNT_W'(QUEUE_DEPTH);

    localparam logic [1:0] KIND_COEF     = 2'd0;
    localparam logic [1:0] KIND_EOB      = 2'd1;
    localparam logic [1:0] KIND_INVALID  = 2'd2;
    localparam logic [1:0] KIND_UNEXP_END = 2'd3;

    typedef enum logic {
        ITEM_DATA,
        ITEM_RESTART
    } acvlc_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FLUSH
    } acvlc_state_t;

    typedef struct packed {
        logic [5:0] run;
        logic [5:0] mag;
    } acvlc_rm_t;

    typedef struct packed {
        logic              valid;
        acvlc_item_t       cls;
        logic [WORD_W-1:0] word;
    } acvlc_qhead_t;

    typedef struct packed {
        logic       ok;
        logic [4:0] len;
        logic [1:0] kind;
        logic [5:0] run;
        logic [9:0] lev;
    } acvlc_code_t;

    localparam acvlc_rm_t TAB_P2 [8] = '{
        '{6'd13, 6'd1}, '{6'd0, 6'd6}, '{6'd12, 6'd1}, '{6'd11, 6'd1},
        '{6'd3, 6'd2},  '{6'd1, 6'd3}, '{6'd0, 6'd5},  '{6'd10, 6'd1}};

    localparam acvlc_rm_t TAB_P3 [4] = '{
        '{6'd7, 6'd1}, '{6'd6, 6'd1}, '{6'd1, 6'd2}, '{6'd5, 6'd1}};

    localparam acvlc_rm_t TAB_P4 [4] = '{
        '{6'd2, 6'd2}, '{6'd9, 6'd1}, '{6'd0, 6'd4}, '{6'd8, 6'd1}};

    localparam acvlc_rm_t TAB_P6 [8] = '{
        '{6'd16, 6'd1}, '{6'd5, 6'd2}, '{6'd0, 6'd7},  '{6'd2, 6'd3},
        '{6'd1, 6'd4},  '{6'd15, 6'd1}, '{6'd14, 6'd1}, '{6'd4, 6'd2}};

    localparam acvlc_rm_t TAB_P7 [16] = '{
        '{6'd0, 6'd11}, '{6'd8, 6'd2},  '{6'd4, 6'd3},  '{6'd0, 6'd10},
        '{6'd2, 6'd4},  '{6'd7, 6'd2},  '{6'd21, 6'd1}, '{6'd20, 6'd1},
        '{6'd0, 6'd9},  '{6'd19, 6'd1}, '{6'd18, 6'd1}, '{6'd1, 6'd5},
        '{6'd3, 6'd3},  '{6'd0, 6'd8},  '{6'd6, 6'd2},  '{6'd17, 6'd1}};

    localparam acvlc_rm_t TAB_P8 [16] = '{
        '{6'd10, 6'd2}, '{6'd9, 6'd2},  '{6'd5, 6'd3},  '{6'd3, 6'd4},
        '{6'd2, 6'd5},  '{6'd1, 6'd7},  '{6'd1, 6'd6},  '{6'd0, 6'd15},
        '{6'd0, 6'd14}, '{6'd0, 6'd13}, '{6'd0, 6'd12}, '{6'd26, 6'd1},
        '{6'd25, 6'd1}, '{6'd24, 6'd1}, '{6'd23, 6'd1}, '{6'd22, 6'd1}};

endpackage

// ----- hdl/acvlc_front.sv -----
// front end: accepts items, classifies them as data or restart and queues them
// two-entry queue towards the back end; uses acvlc_pkg
module acvlc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [acvlc_pkg::WORD_W-1:0] s_data_word,
    input  logic                         q_pop,
    output acvlc_pkg::acvlc_qhead_t      q_head
);

    logic [acvlc_pkg::WORD_W-1:0] word_mem [acvlc_pkg::QUEUE_DEPTH];
    acvlc_pkg::acvlc_item_t       cls_mem  [acvlc_pkg::QUEUE_DEPTH];
    logic [acvlc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [acvlc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [acvlc_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                         push;
    acvlc_pkg::acvlc_item_t       in_cls;

    assign s_ready = (count_reg != acvlc_pkg::Q_FULL);
    assign push    = s_valid && s_ready;
    assign in_cls  = s_op ? acvlc_pkg::ITEM_RESTART : acvlc_pkg::ITEM_DATA;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            word_mem[wr_ptr_reg] <= s_data_word;
            cls_mem[wr_ptr_reg]  <= in_cls;
        end
    end

    always_comb begin
        q_head.valid = (count_reg != '0);
        q_head.cls   = cls_mem[rd_ptr_reg];
        q_head.word  = word_mem[rd_ptr_reg];
    end

endmodule

// ----- hdl/acvlc_code.sv -----
// single-code decoder: finds one vlc at the bottom of the bit window
// gives completeness, length, kind, run and level; uses acvlc_pkg tables
module acvlc_code (
    input  logic [acvlc_pkg::WIN_W-1:0] win,
    input  logic [acvlc_pkg::CNT_W-1:0] cnt,
    output acvlc_pkg::acvlc_code_t      code
);

    always_comb begin
        logic [3:0]           p;
        logic [4:0]           last_idx;
        logic [5:0]           r;
        logic [5:0]           mag;
        logic                 has_sign;
        logic                 esc;
        logic [9:0]           esc_lev;
        logic [3:0]           idx4;
        logic [1:0]           kind;
        acvlc_pkg::acvlc_rm_t ent;

        p        = 4'd12;
        last_idx = 5'd1;
        r        = '0;
        mag      = '0;
        has_sign = 1'b0;
        esc      = 1'b0;
        esc_lev  = '0;
        idx4     = '0;
        kind     = acvlc_pkg::KIND_COEF;
        ent      = '0;

        // first set bit after the two leading zeros
        for (int i = 11; i >= 2; i--) begin
            if (win[i]) begin
                p = 4'(i);
            end
        end

        unique case ({win[0], win[1]})
            2'b10: begin
                kind     = acvlc_pkg::KIND_EOB;
                last_idx = 5'd1;
            end
            2'b11: begin
                mag      = 6'd1;
                last_idx = 5'd2;
                has_sign = 1'b1;
            end
            2'b01: begin
                has_sign = 1'b1;
                if (win[2]) begin
                    r        = 6'd1;
                    mag      = 6'd1;
                    last_idx = 5'd3;
                end else begin
                    last_idx = 5'd4;
                    if (win[3]) begin
                        r   = 6'd2;
                        mag = 6'd1;
                    end else begin
                        mag = 6'd2;
                    end
                end
            end
            default: begin
                has_sign = 1'b1;
                unique case (p)
                    4'd2: begin
                        if (win[3]) begin
                            r        = win[4] ? 6'd3 : 6'd4;
                            mag      = 6'd1;
                            last_idx = 5'd5;
                        end else if (win[4]) begin
                            mag      = 6'd3;
                            last_idx = 5'd5;
                        end else begin
                            last_idx = 5'd8;
                            ent      = acvlc_pkg::TAB_P2[{win[5], win[6], win[7]}];
                            r        = ent.run;
                            mag      = ent.mag;
                        end
                    end
                    4'd3: begin
                        last_idx = 5'd6;
                        ent      = acvlc_pkg::TAB_P3[{win[4], win[5]}];
                        r        = ent.run;
                        mag      = ent.mag;
                    end
                    4'd4: begin
                        last_idx = 5'd7;
                        ent      = acvlc_pkg::TAB_P4[{win[5], win[6]}];
                        r        = ent.run;
                        mag      = ent.mag;
                    end
                    4'd5: begin
                        // escape: 6-bit run then 10-bit level
                        esc      = 1'b1;
                        has_sign = 1'b0;
                        last_idx = 5'd21;
                        r        = {win[6], win[7], win[8], win[9], win[10], win[11]};
                        esc_lev  = {win[12], win[13], win[14], win[15], win[16],
                                    win[17], win[18], win[19], win[20], win[21]};
                    end
                    4'd6: begin
                        last_idx = 5'd10;
                        ent      = acvlc_pkg::TAB_P6[{win[7], win[8], win[9]}];
                        r        = ent.run;
                        mag      = ent.mag;
                    end
                    4'd7: begin
                        last_idx = 5'd12;
                        ent      = acvlc_pkg::TAB_P7[{win[8], win[9], win[10], win[11]}];
                        r        = ent.run;
                        mag      = ent.mag;
                    end
                    4'd8: begin
                        last_idx = 5'd13;
                        ent      = acvlc_pkg::TAB_P8[{win[9], win[10], win[11], win[12]}];
                        r        = ent.run;
                        mag      = ent.mag;
                    end
                    4'd9: begin
                        last_idx = 5'd14;
                        idx4     = {win[10], win[11], win[12], win[13]};
                        mag      = 6'd31 - {2'b00, idx4};
                    end
                    4'd10: begin
                        last_idx = 5'd15;
                        idx4     = {win[11], win[12], win[13], win[14]};
                        if (idx4 < 4'd9) begin
                            mag = 6'd40 - {2'b00, idx4};
                        end else begin
                            r   = 6'd1;
                            mag = 6'd23 - {2'b00, idx4};
                        end
                    end
                    4'd11: begin
                        last_idx = 5'd16;
                        idx4     = {win[12], win[13], win[14], win[15]};
                        if (idx4 < 4'd4) begin
                            r   = 6'd1;
                            mag = 6'd18 - {2'b00, idx4};
                        end else if (idx4 == 4'd4) begin
                            r   = 6'd6;
                            mag = 6'd3;
                        end else if (idx4 < 4'd11) begin
                            r   = 6'd21 - {2'b00, idx4};
                            mag = 6'd2;
                        end else begin
                            r   = 6'd42 - {2'b00, idx4};
                            mag = 6'd1;
                        end
                    end
                    default: begin
                        // twelve leading zeros
                        kind     = acvlc_pkg::KIND_INVALID;
                        has_sign = 1'b0;
                        last_idx = 5'd11;
                    end
                endcase
            end
        endcase

        code.ok   = (cnt > {1'b0, last_idx});
        code.len  = last_idx + 5'd1;
        code.kind = kind;
        code.run  = r;
        if (esc) begin
            code.lev = esc_lev;
        end else if (has_sign && win[last_idx]) begin
            code.lev = 10'd0 - {4'b0000, mag};
        end else begin
            code.lev = {4'b0000, mag};
        end
    end

endmodule

// ----- hdl/acvlc_back.sv -----
// back end: bit buffer, one-code-per-cycle sequencer (held while the output is not free) and result register
// pops items from the front queue; uses acvlc_pkg and acvlc_code
module acvlc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  acvlc_pkg::acvlc_qhead_t        q_head,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [5:0]                     m_zero_run,
    output logic signed [9:0]              m_level,
    output logic                           m_last
);

    acvlc_pkg::acvlc_state_t      state_reg, state_next;
    logic [acvlc_pkg::BUF_W-1:0]  buf_reg, buf_next;
    logic [acvlc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                         halted_reg, halted_next;
    logic [acvlc_pkg::K_W-1:0]    k_reg, k_next;
    logic                         held_valid_reg, held_valid_next;
    logic [1:0]                   held_kind_reg, held_kind_next;
    logic [5:0]                   held_run_reg, held_run_next;
    logic [9:0]                   held_lev_reg, held_lev_next;
    logic                         m_valid_reg, m_valid_next;
    logic [1:0]                   m_kind_reg, m_kind_next;
    logic [5:0]                   m_run_reg, m_run_next;
    logic signed [9:0]            m_level_reg, m_level_next;
    logic                         m_last_reg, m_last_next;
    logic                         out_free;
    logic                         emit;
    logic [1:0]                   e_kind;
    logic [5:0]                   e_run;
    logic [9:0]                   e_lev;
    logic                         e_last;
    acvlc_pkg::acvlc_code_t       code;

    acvlc_code u_code (
        .win  (buf_reg[acvlc_pkg::WIN_W-1:0]),
        .cnt  (cnt_reg),
        .code (code)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            acvlc_pkg::ST_IDLE: begin
                if (q_head.valid && q_head.cls == acvlc_pkg::ITEM_DATA && !halted_reg) begin
                    state_next = acvlc_pkg::ST_DECODE;
                end
            end
            acvlc_pkg::ST_DECODE: begin
                if (out_free) begin
                    if (!code.ok || k_reg == acvlc_pkg::K_LAST) begin
                        state_next = acvlc_pkg::ST_IDLE;
                    end else if (code.kind == acvlc_pkg::KIND_INVALID) begin
                        state_next = acvlc_pkg::ST_FLUSH;
                    end
                end
            end
            acvlc_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = acvlc_pkg::ST_IDLE;
                end
            end
            default: state_next = acvlc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop           = 1'b0;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        halted_next     = halted_reg;
        k_next          = k_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        held_run_next   = held_run_reg;
        held_lev_next   = held_lev_reg;
        emit            = 1'b0;
        e_kind          = held_kind_reg;
        e_run           = held_run_reg;
        e_lev           = held_lev_reg;
        e_last          = 1'b0;

        unique case (state_reg)
            acvlc_pkg::ST_IDLE: begin
                if (q_head.valid) begin
                    if (q_head.cls == acvlc_pkg::ITEM_RESTART) begin
                        if (!halted_reg && cnt_reg != '0) begin
                            // truncated code pending
                            if (out_free) begin
                                q_pop       = 1'b1;
                                emit        = 1'b1;
                                e_kind      = acvlc_pkg::KIND_UNEXP_END;
                                e_run       = '0;
                                e_lev       = '0;
                                e_last      = 1'b1;
                                buf_next    = '0;
                                cnt_next    = '0;
                                halted_next = 1'b0;
                            end
                        end else begin
                            q_pop       = 1'b1;
                            buf_next    = '0;
                            cnt_next    = '0;
                            halted_next = 1'b0;
                        end
                    end else begin
                        q_pop = 1'b1;
                        if (!halted_reg) begin
                            buf_next = buf_reg
                                     | ({{(acvlc_pkg::BUF_W - acvlc_pkg::WORD_W){1'b0}},
                                         q_head.word} << cnt_reg);
                            cnt_next        = cnt_reg + acvlc_pkg::WORD_CNT;
                            k_next          = '0;
                            held_valid_next = 1'b0;
                        end
                    end
                end
            end
            acvlc_pkg::ST_DECODE: begin
                if (out_free) begin
                    if (!code.ok) begin
                        emit   = held_valid_reg;
                        e_last = 1'b1;
                    end else if (k_reg == acvlc_pkg::K_LAST) begin
                        // seventh code: sixth result turns into invalid
                        emit        = 1'b1;
                        e_kind      = acvlc_pkg::KIND_INVALID;
                        e_run       = '0;
                        e_lev       = '0;
                        e_last      = 1'b1;
                        halted_next = 1'b1;
                        buf_next    = '0;
                        cnt_next    = '0;
                    end else begin
                        emit            = held_valid_reg;
                        held_valid_next = 1'b1;
                        held_kind_next  = code.kind;
                        held_run_next   = code.run;
                        held_lev_next   = code.lev;
                        k_next          = k_reg + 1'b1;
                        if (code.kind == acvlc_pkg::KIND_INVALID) begin
                            halted_next = 1'b1;
                            buf_next    = '0;
                            cnt_next    = '0;
                        end else begin
                            buf_next = buf_reg >> code.len;
                            cnt_next = cnt_reg - {1'b0, code.len};
                        end
                    end
                end
            end
            acvlc_pkg::ST_FLUSH: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        m_valid_next = m_valid_reg;
        m_kind_next  = m_kind_reg;
        m_run_next   = m_run_reg;
        m_level_next = m_level_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_kind_next  = e_kind;
            m_run_next   = e_run;
            m_level_next = $signed(e_lev);
            m_last_next  = e_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= acvlc_pkg::ST_IDLE;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            halted_reg     <= 1'b0;
            k_reg          <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            halted_reg     <= halted_next;
            k_reg          <= k_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_kind_reg <= held_kind_next;
        held_run_reg  <= held_run_next;
        held_lev_reg  <= held_lev_next;
        m_kind_reg    <= m_kind_next;
        m_run_reg     <= m_run_next;
        m_level_reg   <= m_level_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_zero_run = m_run_reg;
    assign m_level    = m_level_reg;
    assign m_last     = m_last_reg;

`ifndef SYNTHESIS
    a_halted_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> cnt_reg == '0)
        else $error("pending bits held while halted");

    a_idle_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == acvlc_pkg::ST_IDLE |-> cnt_reg <= acvlc_pkg::PEND_MAX)
        else $error("too many pending bits between items");

    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= acvlc_pkg::K_LAST)
        else $error("result count overran");

    a_flush_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == acvlc_pkg::ST_FLUSH |-> halted_reg && held_valid_reg)
        else $error("flush without held invalid result");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_kind_reg == acvlc_pkg::KIND_INVALID
                        || m_kind_reg == acvlc_pkg::KIND_UNEXP_END) |-> m_last_reg)
        else $error("error result not flagged last");
`endif

endmodule

// ----- hdl/ac_run_level_vlc_decoder_top.sv -----
// order: an accepted data item is queued, then loaded into the bit buffer when the back end
// pops it in idle; its first result is registered once the next code is decoded or the item ends
// throughput: one code decoded per cycle while the output register is free; a data item holds
// the back end until its codes are done; a two-item queue decouples input
// reset: synchronous active-low aresetn clears queue, pending bits, halt flag and output
// top level: front queue and back decoder; uses acvlc_pkg, acvlc_front, acvlc_back
module ac_run_level_vlc_decoder_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_op,
    input  logic [acvlc_pkg::WORD_W-1:0] s_data_word,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_kind,
    output logic [5:0]                   m_zero_run,
    output logic signed [9:0]            m_level,
    output logic                         m_last
);

    acvlc_pkg::acvlc_qhead_t q_head;
    logic                    q_pop;

    acvlc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_word (s_data_word),
        .q_pop       (q_pop),
        .q_head      (q_head)
    );

    acvlc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_kind     (m_kind),
        .m_zero_run (m_zero_run),
        .m_level    (m_level),
        .m_last     (m_last)
    );

endmodule

// ----- bench/vlc_result_checker.sv -----
`timescale 1ns / 100ps
// result checker for the ac run/level vlc decoder: watches both channels, decodes every
// accepted data word outside a halt with its own copy of the code table and compares each result item
// depends on acvlc_pkg for widths, result kinds and item classes
module vlc_result_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_op,
    input  logic [acvlc_pkg::WORD_W-1:0] s_data_word,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [1:0]                   m_kind,
    input  logic [5:0]                   m_zero_run,
    input  logic signed [9:0]            m_level,
    input  logic                         m_last,
    output int                           mismatches,
    output int                           awaited
);

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] run;
        logic [9:0] lev;
        logic       last;
    } vlc_result_t;

    typedef struct packed {
        int         len;
        logic [1:0] kind;
        logic [5:0] run;
        logic [9:0] lev;
    } vlc_code_t;

    // {run, magnitude} pairs, entry 0 first
    localparam logic [191:0] P2_TAB = 192'({
        6'd13, 6'd1, 6'd0, 6'd6, 6'd12, 6'd1, 6'd11, 6'd1,
        6'd3, 6'd2, 6'd1, 6'd3, 6'd0, 6'd5, 6'd10, 6'd1});
    localparam logic [191:0] P3_TAB = 192'({
        6'd7, 6'd1, 6'd6, 6'd1, 6'd1, 6'd2, 6'd5, 6'd1});
    localparam logic [191:0] P4_TAB = 192'({
        6'd2, 6'd2, 6'd9, 6'd1, 6'd0, 6'd4, 6'd8, 6'd1});
    localparam logic [191:0] P6_TAB = 192'({
        6'd16, 6'd1, 6'd5, 6'd2, 6'd0, 6'd7, 6'd2, 6'd3,
        6'd1, 6'd4, 6'd15, 6'd1, 6'd14, 6'd1, 6'd4, 6'd2});
    localparam logic [191:0] P7_TAB = {
        6'd0, 6'd11, 6'd8, 6'd2, 6'd4, 6'd3, 6'd0, 6'd10,
        6'd2, 6'd4, 6'd7, 6'd2, 6'd21, 6'd1, 6'd20, 6'd1,
        6'd0, 6'd9, 6'd19, 6'd1, 6'd18, 6'd1, 6'd1, 6'd5,
        6'd3, 6'd3, 6'd0, 6'd8, 6'd6, 6'd2, 6'd17, 6'd1};
    localparam logic [191:0] P8_TAB = {
        6'd10, 6'd2, 6'd9, 6'd2, 6'd5, 6'd3, 6'd3, 6'd4,
        6'd2, 6'd5, 6'd1, 6'd7, 6'd1, 6'd6, 6'd0, 6'd15,
        6'd0, 6'd14, 6'd0, 6'd13, 6'd0, 6'd12, 6'd26, 6'd1,
        6'd25, 6'd1, 6'd24, 6'd1, 6'd23, 6'd1, 6'd22, 6'd1};

    logic [21:0] pend_bits;
    int          pend_cnt;
    bit          halted;
    int          result_no;
    vlc_result_t awaited_results[$];

    initial begin
        mismatches = 0;
        result_no  = 0;
        pend_bits  = '0;
        pend_cnt   = 0;
        halted     = 0;
    end

    function automatic logic [11:0] pick(input logic [191:0] tab, input int entries,
                                         input int idx);
        return tab[(entries - 1 - idx) * 12 +: 12];
    endfunction

    // bits in consumption order, first one most significant
    function automatic int peek_msb(input logic [63:0] b, input int pos, input int len);
        int v;
        int i;
        v = 0;
        for (i = 0; i < len; i++) v = (v << 1) | int'(b[pos + i]);
        return v;
    endfunction

    // len 0 means the code is not complete yet
    function automatic vlc_code_t decode_code(input logic [63:0] b, input int n);
        vlc_code_t   c;
        int          p;
        int          sp;
        int          idx;
        int          r;
        int          mag;
        logic [11:0] e;
        logic [15:0] esc;
        c.len  = 0;
        c.kind = acvlc_pkg::KIND_COEF;
        c.run  = '0;
        c.lev  = '0;
        sp     = 0;
        r      = 0;
        mag    = 0;
        if (n < 2) return c;
        if (b[0] && !b[1]) begin
            c.kind = acvlc_pkg::KIND_EOB;
            c.len  = 2;
            return c;
        end
        if (b[0]) begin
            mag = 1;
            sp  = 2;
        end else if (b[1]) begin
            if (n < 3) return c;
            if (b[2]) begin
                r   = 1;
                mag = 1;
                sp  = 3;
            end else begin
                if (n < 4) return c;
                if (b[3]) begin
                    r   = 2;
                    mag = 1;
                end else begin
                    mag = 2;
                end
                sp = 4;
            end
        end else begin
            p = 2;
            while (p < 12 && p < n && !b[p]) p++;
            if (p < 12 && p >= n) return c;
            if (p == 12) begin
                c.kind = acvlc_pkg::KIND_INVALID;
                c.len  = 12;
                return c;
            end
            if (p == 5) begin
                if (n < 22) return c;
                esc   = 16'(peek_msb(b, 6, 16));
                c.run = esc[15:10];
                c.lev = esc[9:0];
                c.len = 22;
                return c;
            end
            if (p == 2) begin
                if (n <= 5) return c;
                if (b[3]) begin
                    r   = b[4] ? 3 : 4;
                    mag = 1;
                    sp  = 5;
                end else if (b[4]) begin
                    mag = 3;
                    sp  = 5;
                end else begin
                    sp = 8;
                    if (sp >= n) return c;
                    e   = pick(P2_TAB, 8, peek_msb(b, 5, 3));
                    r   = int'(e[11:6]);
                    mag = int'(e[5:0]);
                end
            end else if (p < 5) begin
                sp = p + 3;
                if (sp >= n) return c;
                idx = peek_msb(b, p + 1, 2);
                e   = (p == 3) ? pick(P3_TAB, 4, idx) : pick(P4_TAB, 4, idx);
                r   = int'(e[11:6]);
                mag = int'(e[5:0]);
            end else begin
                sp = (p == 6) ? 10 : p + 5;
                if (sp >= n) return c;
                idx = peek_msb(b, p + 1, (p == 6) ? 3 : 4);
                case (p)
                    6: e = pick(P6_TAB, 8, idx);
                    7: e = pick(P7_TAB, 16, idx);
                    8: e = pick(P8_TAB, 16, idx);
                    9: e = {6'd0, 6'(31 - idx)};
                    10: begin
                        if (idx < 9) e = {6'd0, 6'(40 - idx)};
                        else e = {6'd1, 6'(23 - idx)};
                    end
                    default: begin
                        if (idx < 4) e = {6'd1, 6'(18 - idx)};
                        else if (idx == 4) e = {6'd6, 6'd3};
                        else if (idx < 11) e = {6'(21 - idx), 6'd2};
                        else e = {6'(42 - idx), 6'd1};
                    end
                endcase
                r   = int'(e[11:6]);
                mag = int'(e[5:0]);
            end
        end
        if (sp >= n) return c;
        c.run = 6'(r);
        c.lev = b[sp] ? 10'(-mag) : 10'(mag);
        c.len = sp + 1;
        return c;
    endfunction

    task automatic push_result(input logic [1:0] kind, input logic [5:0] run,
                               input logic [9:0] lev, input logic last);
        vlc_result_t res;
        res.kind = kind;
        res.run  = run;
        res.lev  = lev;
        res.last = last;
        awaited_results.push_back(res);
    endtask

    task automatic decode_word(input logic [15:0] word);
        vlc_code_t   codes[7];
        logic [63:0] stream;
        int          avail;
        int          k;
        int          i;
        bit          more;
        stream = 64'(pend_bits) | (64'(word) << pend_cnt);
        avail  = pend_cnt + 16;
        k      = 0;
        more   = 1;
        while (more && k < 7) begin
            codes[k] = decode_code(stream, avail);
            if (codes[k].len == 0) begin
                more = 0;
            end else begin
                stream = stream >> codes[k].len;
                avail  = avail - codes[k].len;
                if (codes[k].kind == acvlc_pkg::KIND_INVALID) begin
                    halted = 1;
                    more   = 0;
                end
                k++;
            end
        end
        // seventh code in one word: the sixth result turns into invalid
        if (k == 7) begin
            k              = 6;
            codes[5].kind  = acvlc_pkg::KIND_INVALID;
            codes[5].run   = '0;
            codes[5].lev   = '0;
            halted         = 1;
        end
        if (halted) begin
            pend_bits = '0;
            pend_cnt  = 0;
        end else begin
            pend_bits = stream[21:0];
            pend_cnt  = avail;
        end
        for (i = 0; i < k; i++) push_result(codes[i].kind, codes[i].run, codes[i].lev, i == k - 1);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch on result item %0d: %s", $time, result_no, msg);
        mismatches++;
    endtask

    task automatic check_result();
        vlc_result_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch($sformatf("none expected, got kind %0d run %0d level %0d",
                                      m_kind, m_zero_run, m_level));
            return;
        end
        want = awaited_results.pop_front();
        if (m_kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", m_kind, want.kind));
        if (m_zero_run !== want.run)
            report_mismatch($sformatf("zero_run %0d, expected %0d", m_zero_run, want.run));
        if (m_level !== want.lev)
            report_mismatch($sformatf("level %0d, expected %0d", m_level, $signed(want.lev)));
        if (m_last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", m_last, want.last));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits = '0;
            pend_cnt  = 0;
            halted    = 0;
            awaited_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result();
                result_no++;
            end
            if (s_valid && s_ready) begin
                if (s_op == acvlc_pkg::ITEM_RESTART) begin
                    if (!halted && pend_cnt > 0)
                        push_result(acvlc_pkg::KIND_UNEXP_END, '0, '0, 1'b1);
                    pend_bits = '0;
                    pend_cnt  = 0;
                    halted    = 0;
                end else if (!halted) begin
                    decode_word(s_data_word);
                end
            end
        end
        awaited <= awaited_results.size();
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// testbench top for the ac run/level vlc decoder: builds code streams, restarts and noise
// words, idles both channels at random and gives the verdict
// depends on acvlc_pkg, ac_run_level_vlc_decoder_top and vlc_result_checker
module tb_top;

    localparam int ITEM_TARGET = 260;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic                         s_op = acvlc_pkg::ITEM_DATA;
    logic [acvlc_pkg::WORD_W-1:0] s_data_word = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_kind;
    logic [5:0]                   m_zero_run;
    logic signed [9:0]            m_level;
    logic                         m_last;

    int mismatches;
    int awaited;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit idle_on = 1;
    bit code_bits[$];

    ac_run_level_vlc_decoder_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_word (s_data_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_zero_run  (m_zero_run),
        .m_level     (m_level),
        .m_last      (m_last)
    );

    vlc_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_word (s_data_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_zero_run  (m_zero_run),
        .m_level     (m_level),
        .m_last      (m_last),
        .mismatches  (mismatches),
        .awaited     (awaited)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= aresetn && (!idle_on || $urandom_range(99) >= 25);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input acvlc_pkg::acvlc_item_t op,
                             input logic [acvlc_pkg::WORD_W-1:0] word);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_data_word <= word;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic push_bits(input int value, input int width);
        int i;
        for (i = width - 1; i >= 0; i--) code_bits.push_back(value[i]);
    endtask

    // one code with the given number of leading zeros, random tail; twelve zeros give the invalid code
    task automatic push_random_code(input int zeros);
        int first;
        int second;
        push_bits(0, zeros);
        if (zeros == 12) return;
        code_bits.push_back(1'b1);
        case (zeros)
            0: begin
                first = $urandom_range(1);
                code_bits.push_back(1'(first));
                if (first) push_bits($urandom, 1);
            end
            1: begin
                first = $urandom_range(1);
                code_bits.push_back(1'(first));
                push_bits($urandom, first ? 1 : 2);
            end
            2: begin
                first  = $urandom_range(1);
                second = $urandom_range(1);
                code_bits.push_back(1'(first));
                code_bits.push_back(1'(second));
                push_bits($urandom, (first || second) ? 1 : 4);
            end
            3, 4: push_bits($urandom, 3);
            5: push_bits($urandom, 16);
            6: push_bits($urandom, 4);
            default: push_bits($urandom, 5);
        endcase
    endtask

    task automatic push_escape(input int run, input int lev);
        push_bits(1, 6);
        push_bits(run, 6);
        push_bits(lev, 10);
    endtask

    // packs queued bits into words, bit 0 first; a padded tail is completed at random
    task automatic send_bits(input bit pad_tail);
        logic [acvlc_pkg::WORD_W-1:0] w;
        int i;
        if (pad_tail)
            while (code_bits.size() % acvlc_pkg::WORD_W != 0)
                code_bits.push_back(1'($urandom_range(1)));
        while (code_bits.size() >= acvlc_pkg::WORD_W) begin
            for (i = 0; i < acvlc_pkg::WORD_W; i++) w[i] = code_bits.pop_front();
            send_item(acvlc_pkg::ITEM_DATA, w);
        end
    endtask

    function automatic int random_zeros();
        int w;
        w = $urandom_range(99);
        if (w < 35) return $urandom_range(1);
        if (w < 50) return 2;
        if (w < 60) return 5;
        return $urandom_range(11);
    endfunction

    initial begin
        int sel;
        int ncodes;
        int z;
        bit dense;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_item(acvlc_pkg::ITEM_RESTART, 16'hFFFF);
        send_item(acvlc_pkg::ITEM_DATA, 16'h0000);
        send_item(acvlc_pkg::ITEM_DATA, 16'hFFFF);
        send_item(acvlc_pkg::ITEM_RESTART, 16'h0000);
        // eight end-of-block codes in one word
        send_item(acvlc_pkg::ITEM_DATA, 16'h5555);
        send_item(acvlc_pkg::ITEM_RESTART, 16'h0000);
        // five level -1 codes and a truncated one
        send_item(acvlc_pkg::ITEM_DATA, 16'hFFFF);
        send_item(acvlc_pkg::ITEM_RESTART, 16'h1234);
        push_escape(63, 10'h200);
        push_escape(0, 0);
        push_escape(0, 10'h1FF);
        push_escape(1, 10'h3FF);
        for (z = 0; z < 12; z++) push_random_code(z);
        send_bits(1);
        send_item(acvlc_pkg::ITEM_RESTART, 16'h0000);

        while (items_sent < ITEM_TARGET) begin
            idle_on = !(items_sent >= 110 && items_sent < 170);
            sel = $urandom_range(99);
            if (sel < 80) begin
                ncodes = $urandom_range(1, 24);
                dense  = ($urandom_range(99) < 15);
                repeat (ncodes) push_random_code(dense ? 0 : random_zeros());
                if ($urandom_range(9) == 0) begin
                    push_random_code(12);
                    send_bits(1);
                    code_bits.delete();
                    send_item(acvlc_pkg::ITEM_RESTART, 16'($urandom));
                end else if ($urandom_range(9) < 4) begin
                    send_bits(1);
                    send_item(acvlc_pkg::ITEM_RESTART, 16'($urandom));
                end else begin
                    send_bits(0);
                end
            end else if (sel < 92) begin
                send_item(acvlc_pkg::ITEM_DATA, 16'($urandom));
            end else begin
                send_item(acvlc_pkg::ITEM_RESTART, 16'($urandom));
            end
        end

        idle_on = 1;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
